// ===== rtl/core/ssw_pkg.sv =====
package ssw_pkg;

    // operation codes of a command item
    localparam logic [2:0] OP_RAW       = 3'd0;
    localparam logic [2:0] OP_CLR_DIGIT = 3'd1;
    localparam logic [2:0] OP_CLR_LINE  = 3'd2;
    localparam logic [2:0] OP_CLR_ALL   = 3'd3;
    localparam logic [2:0] OP_HEX16     = 3'd4;
    localparam logic [2:0] OP_HEX8      = 3'd5;
    localparam logic [2:0] OP_DEC16     = 3'd6;
    localparam logic [2:0] OP_ERR       = 3'd7;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_LETTER_E = 2'd0;
    localparam logic [1:0]  CFG_LETTER_R = 2'd1;
    localparam logic [6:0]  LETTER_E_RST = 7'd79;
    localparam logic [6:0]  LETTER_R_RST = 7'd10;

    // controller byte codes
    localparam logic [7:0] CTRL_HEX   = 8'h58;
    localparam logic [7:0] CTRL_NODEC = 8'h78;
    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] BLANK_DATA = 8'h80;

    // divide by ten: (v * 52429) >> 19 is exact for every 16-bit v
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        K_RAW   = 3'd0,
        K_BLANK = 3'd1,
        K_HEX   = 3'd2,
        K_DEC   = 3'd3,
        K_ERR   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  digit_address;
        logic [7:0]  data_byte;
        logic        decode_hex;
        logic        point_on;
        logic        line;
        logic [15:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       control_select;
        logic       last;
    } t_result;

    // classified command, as handed from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  start_addr;
        logic        addr_down;
        logic [2:0]  last_idx;
        logic [7:0]  data;
        logic        hex;
        logic [15:0] value;
    } t_desc;

    typedef struct packed {
        logic [6:0] letter_e;
        logic [6:0] letter_r;
    } t_patterns;

endpackage

// ===== rtl/core/ssw_front.sv =====
module ssw_front import ssw_pkg::*; (
    input  t_cmd_in i_cmd,
    output t_desc   o_desc
);

    logic [2:0] line_base;

    assign line_base = {i_cmd.line, 2'b00};

    always_comb begin
        o_desc           = '0;
        o_desc.kind      = K_ERR;
        o_desc.start_addr = line_base;
        o_desc.addr_down = 1'b0;
        o_desc.last_idx  = 3'd3;
        o_desc.data      = BLANK_DATA;
        o_desc.hex       = 1'b0;
        o_desc.value     = i_cmd.value;
        case (i_cmd.operation)
            OP_RAW: begin
                o_desc.kind       = K_RAW;
                o_desc.start_addr = i_cmd.digit_address;
                o_desc.last_idx   = 3'd0;
                o_desc.data       = {~i_cmd.point_on, i_cmd.data_byte[6:0]};
                o_desc.hex        = i_cmd.decode_hex;
            end
            OP_CLR_DIGIT: begin
                o_desc.kind       = K_BLANK;
                o_desc.start_addr = i_cmd.digit_address;
                o_desc.last_idx   = 3'd0;
            end
            OP_CLR_LINE: begin
                o_desc.kind = K_BLANK;
            end
            OP_CLR_ALL: begin
                o_desc.kind       = K_BLANK;
                o_desc.start_addr = 3'd0;
                o_desc.last_idx   = 3'd7;
            end
            OP_HEX16: begin
                o_desc.kind = K_HEX;
                o_desc.hex  = 1'b1;
            end
            OP_HEX8: begin
                // low byte moved up so the same nibble walk serves it
                o_desc.kind       = K_HEX;
                o_desc.hex        = 1'b1;
                o_desc.start_addr = i_cmd.digit_address;
                o_desc.last_idx   = 3'd1;
                o_desc.value      = {i_cmd.value[7:0], 8'h00};
            end
            OP_DEC16: begin
                o_desc.kind       = K_DEC;
                o_desc.hex        = 1'b1;
                o_desc.start_addr = {i_cmd.line, 2'b11};
                o_desc.addr_down  = 1'b1;
            end
            OP_ERR: begin
                o_desc.kind = K_ERR;
            end
            default: begin
                o_desc.kind = K_ERR;
            end
        endcase
    end

endmodule

// ===== rtl/core/ssw_cmd_queue.sv =====
module ssw_cmd_queue import ssw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc      r_entry [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       do_wr, do_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_entry[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = do_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 2'd1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== rtl/core/ssw_back.sv =====
module ssw_back import ssw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_patterns i_patterns,
    input  logic      i_desc_valid,
    input  t_desc     i_desc,
    output logic      o_desc_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_result   o_result
);

    typedef enum logic [1:0] {
        PH_CTRL = 2'b01,
        PH_DATA = 2'b10
    } t_phase;

    logic        r_busy,  n_busy;
    t_desc       r_cmd,   n_cmd;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx,   n_idx;
    logic [2:0]  r_addr,  n_addr;
    logic [15:0] r_v,     n_v;
    logic [15:0] r_q,     n_q;

    // output queue
    t_result     r_out [2];
    logic        r_out_wr, r_out_rd;
    logic [1:0]  r_out_cnt;
    logic        out_full, out_push, out_pop;
    t_result     item;

    logic        advance, is_last;
    logic [32:0] prod;
    logic [15:0] q_times_ten;
    logic [3:0]  rem;
    logic [7:0]  data_byte;
    logic        use_hex;

    assign out_full = (r_out_cnt == 2'd2);
    assign o_empty  = (r_out_cnt == 2'd0);
    assign out_pop  = i_pop && !o_empty;
    assign o_result = r_out[r_out_rd];

    assign advance  = r_busy && !out_full;
    assign out_push = advance;
    assign is_last  = (r_idx == r_cmd.last_idx);
    assign o_desc_take = i_desc_valid
        && (!r_busy || (advance && r_phase == PH_DATA && is_last));

    // quotient is taken on the control write, the digit on the data write
    assign prod        = r_v * RECIP_TEN;
    assign q_times_ten = {r_q[12:0], 3'b000} + {r_q[14:0], 1'b0};
    assign rem         = r_v[3:0] - q_times_ten[3:0];

    always_comb begin
        use_hex   = r_cmd.hex;
        data_byte = BLANK_DATA;
        case (r_cmd.kind)
            K_RAW:   data_byte = r_cmd.data;
            K_BLANK: data_byte = BLANK_DATA;
            K_HEX:   data_byte = POINT_BIT | {4'h0, r_v[15:12]};
            K_DEC:   data_byte = POINT_BIT | {4'h0, rem};
            K_ERR: begin
                case (r_idx)
                    3'd0:    data_byte = {1'b1, i_patterns.letter_e};
                    3'd1:    data_byte = {1'b1, i_patterns.letter_r};
                    3'd2:    data_byte = {1'b1, i_patterns.letter_r};
                    default: data_byte = BLANK_DATA;
                endcase
            end
            default: data_byte = BLANK_DATA;
        endcase
    end

    always_comb begin
        item = '0;
        if (r_phase == PH_CTRL) begin
            item.bus_byte       = (use_hex ? CTRL_HEX : CTRL_NODEC) | {5'b0, r_addr};
            item.control_select = 1'b1;
            item.last           = 1'b0;
        end else begin
            item.bus_byte       = data_byte;
            item.control_select = 1'b0;
            item.last           = is_last;
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_v     = r_v;
        n_q     = r_q;
        if (advance) begin
            case (r_phase)
                PH_CTRL: begin
                    n_phase = PH_DATA;
                    n_q     = {2'b00, prod[32:RECIP_SHIFT]};
                end
                PH_DATA: begin
                    n_phase = PH_CTRL;
                    if (is_last) begin
                        n_busy = 1'b0;
                    end else begin
                        n_idx  = r_idx + 3'd1;
                        n_addr = r_cmd.addr_down ? r_addr - 3'd1 : r_addr + 3'd1;
                        n_v    = (r_cmd.kind == K_DEC) ? r_q : {r_v[11:0], 4'h0};
                    end
                end
                default: n_phase = PH_CTRL;
            endcase
        end
        if (o_desc_take) begin
            n_busy  = 1'b1;
            n_cmd   = i_desc;
            n_phase = PH_CTRL;
            n_idx   = 3'd0;
            n_addr  = i_desc.start_addr;
            n_v     = i_desc.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_phase   <= PH_CTRL;
            r_idx     <= 3'd0;
            r_out_wr  <= 1'b0;
            r_out_rd  <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (out_push) begin
                r_out_wr <= ~r_out_wr;
            end
            if (out_pop) begin
                r_out_rd <= ~r_out_rd;
            end
            if (out_push && !out_pop) begin
                r_out_cnt <= r_out_cnt + 2'd1;
            end else if (out_pop && !out_push) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_v    <= n_v;
        r_q    <= n_q;
        if (out_push) begin
            r_out[r_out_wr] <= item;
        end
    end

endmodule

// ===== rtl/core/seven_segment_command_writer.sv =====
// Seven-segment command writer: each command item taken from the push side
// becomes the byte writes of an eight-digit parallel display controller,
// a control byte (decode mode and digit address) then a data byte for each
// digit, with last set on the final byte of the command. Every result item
// stands for one strobe. Raw digit and clear digit give 2 items, hex8 gives
// 4, clear line, hex16, decimal16 and err give 8, clear all gives 16. The
// back end emits one byte per cycle while its output queue is not full, and
// commands follow each other with no gap; a two-entry command queue keeps the
// input open while the back end works, and a two-entry output queue decouples
// it from pop. Registers 0 and 1 of the configuration channel hold the
// no-decode patterns of E and r; other indexes are ignored and the channel
// is always ready.
module seven_segment_command_writer import ssw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command side
    input  logic                 push,
    output logic                 full,
    input  t_cmd_in              i_cmd,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]           i_cfg_data
);

    t_patterns r_patterns;
    t_desc     front_desc;
    t_desc     queue_desc;
    logic      queue_valid;
    logic      queue_take;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patterns.letter_e <= LETTER_E_RST;
            r_patterns.letter_r <= LETTER_R_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LETTER_E: r_patterns.letter_e <= i_cfg_data;
                CFG_LETTER_R: r_patterns.letter_r <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: sort the command into a digit walk
    ssw_front u_front (
        .i_cmd  (i_cmd),
        .o_desc (front_desc)
    );

    // short queue between front and back
    ssw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_desc  (front_desc),
        .o_full  (full),
        .i_rd    (queue_take),
        .o_valid (queue_valid),
        .o_desc  (queue_desc)
    );

    // back: walk the digits, one byte write per cycle while the output queue has room
    ssw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_patterns   (r_patterns),
        .i_desc_valid (queue_valid),
        .i_desc       (queue_desc),
        .o_desc_take  (queue_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule
